>>> rtl/assert_macros.svh
// Assertion helpers, clocked on aclk and quiet while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PHAC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PHAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/phac_pkg.sv
package phac_pkg;

    localparam int COUNT_W = 25;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 25'd16777216;
    localparam logic [COUNT_W-1:0] PEAK_RESET  = 25'd256;

    localparam int BLK_W = 3;
    localparam int POS_W = 6;

    localparam logic MODE_COUNT = 1'b0;
    localparam logic MODE_READ  = 1'b1;

endpackage

>>> rtl/phac_bin_ram.sv
module phac_bin_ram
    import phac_pkg::*;
#(
    parameter int DEPTH  = 32768,
    parameter int ADDR_W = 15
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  logic [COUNT_W-1:0] wdata,
    input  logic               re,
    input  logic [ADDR_W-1:0]  raddr,
    output logic [COUNT_W-1:0] rdata
);

    logic [COUNT_W-1:0] mem [DEPTH];
    logic [COUNT_W-1:0] rdata_reg;

    // read returns the old word when the same entry is written in that cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/position_histogram_accumulator.sv
// Position histogram accumulator: one saturating 25-bit count per bin for
// BLOCK_COUNT blocks of BIN_SIDE x BIN_SIDE bins, plus a running peak.
//
// Input stream (s_): one event record per transfer. tuser carries the mode
// (count or read) and the event-valid flag, tdata the block/x/y address,
// tlast the end-of-batch mark. Output stream (m_): exactly one result per
// input transfer, in order: bin count after the item and the peak in
// tdata, the skipped flag in tuser, tlast echoing the input tlast.
//
// Throughput is one transfer per cycle while the receiver keeps m_tready high.
// m_tvalid rises once the item leaves stage 1: the bin RAM is read at the
// accepting edge, and increment, peak update and write-back load the output
// register when stage 1 advances. Back-to-back hits on one bin are served by
// forwarding the value being written, so no bubble is inserted.
//
// After reset the bin RAM is swept to zero, one entry per cycle, across all
// BLOCK_COUNT*BIN_SIDE*BIN_SIDE entries (32768 at the defaults);
// s_tready stays low during the sweep. The peak restarts at 256.
// When the receiver holds m_tready low the result register and the
// pipeline stage behind it hold, and s_tready drops once both are full.
module position_histogram_accumulator
    import phac_pkg::*;
#(
    parameter int BLOCK_COUNT = 8,
    parameter int BIN_SIDE    = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // block_index[2:0], pos_x[8:3], pos_y[14:9], zero fill
    input  logic [1:0]  s_tuser,   // mode[0], event_valid[1]
    input  logic        s_tlast,   // last_in_batch

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // bin_count[24:0], peak_count[49:25], zero fill
    output logic [0:0]  m_tuser,   // was_skipped[0]
    output logic        m_tlast    // batch_done
);

    `include "assert_macros.svh"

    localparam int STORE_DEPTH = BLOCK_COUNT * BIN_SIDE * BIN_SIDE;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // ---------------- input decode ----------------
    logic [BLK_W-1:0]  in_blk;
    logic [POS_W-1:0]  in_x;
    logic [POS_W-1:0]  in_y;
    logic              in_mode;
    logic              in_evt;
    logic              in_range;
    logic [ADDR_W-1:0] in_addr;
    logic              s_fire;

    assign in_blk  = s_tdata[2:0];
    assign in_x    = s_tdata[8:3];
    assign in_y    = s_tdata[14:9];
    assign in_mode = s_tuser[0];
    assign in_evt  = s_tuser[1];

    assign in_range = (int'(in_blk) < BLOCK_COUNT) && (int'(in_x) < BIN_SIDE)
                      && (int'(in_y) < BIN_SIDE);
    // linear bin index: block-major, then row, then column
    assign in_addr  = ADDR_W'((int'(in_blk) * BIN_SIDE + int'(in_y)) * BIN_SIDE
                              + int'(in_x));

    // ---------------- registers ----------------
    logic               clr_active_reg;
    logic [ADDR_W-1:0]  clr_addr_reg;

    // stage 1: RAM data is valid here
    logic               s1_valid_reg;
    logic               s1_mode_reg;
    logic               s1_evt_reg;
    logic               s1_range_reg;
    logic               s1_last_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic               fwd_hit_reg;
    logic [COUNT_W-1:0] fwd_val_reg;

    logic [COUNT_W-1:0] peak_reg;

    // output register
    logic               m_valid_reg;
    logic [COUNT_W-1:0] m_count_reg;
    logic [COUNT_W-1:0] m_peak_reg;
    logic               m_skip_reg;
    logic               m_last_reg;

    // ---------------- stage 1 modify ----------------
    logic [COUNT_W-1:0] ram_rdata;
    logic [COUNT_W-1:0] count_cur;
    logic [COUNT_W-1:0] count_next;
    logic [COUNT_W-1:0] peak_next;
    logic               s1_adv;
    logic               s1_write;
    logic               s1_skip;

    assign s1_adv   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !clr_active_reg && (!s1_valid_reg || s1_adv);
    assign s_fire   = s_tvalid && s_tready;

    // the previous item's write-back lands in the same edge as this read
    assign count_cur = fwd_hit_reg ? fwd_val_reg : ram_rdata;
    assign s1_write  = s1_adv && s1_range_reg && (s1_mode_reg == MODE_COUNT) && s1_evt_reg;
    assign s1_skip   = (s1_mode_reg == MODE_COUNT) && !(s1_range_reg && s1_evt_reg);

    always_comb begin
        if (!s1_range_reg) begin
            count_next = '0;
        end else if (s1_write && (count_cur < COUNT_LIMIT)) begin
            count_next = count_cur + COUNT_W'(1);
        end else begin
            count_next = count_cur;
        end
        peak_next = (s1_write && (count_next > peak_reg)) ? count_next : peak_reg;
    end

    // ---------------- bin RAM ----------------
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [COUNT_W-1:0] ram_wdata;

    assign ram_we    = clr_active_reg || s1_write;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = clr_active_reg ? '0 : count_next;

    phac_bin_ram #(
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_bin_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_fire),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // ---------------- control ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            peak_reg       <= PEAK_RESET;
        end else begin
            if (clr_active_reg) begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (s_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                m_valid_reg <= 1'b1;
                peak_reg    <= peak_next;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_mode_reg  <= in_mode;
            s1_evt_reg   <= in_evt;
            s1_range_reg <= in_range;
            s1_last_reg  <= s_tlast;
            s1_addr_reg  <= in_addr;
            fwd_hit_reg  <= s1_write && in_range && (s1_addr_reg == in_addr);
            fwd_val_reg  <= count_next;
        end
        if (s1_adv) begin
            m_count_reg <= count_next;
            m_peak_reg  <= peak_next;
            m_skip_reg  <= s1_skip;
            m_last_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_peak_reg, m_count_reg};
    assign m_tuser  = m_skip_reg;
    assign m_tlast  = m_last_reg;

    // ---------------- assertions ----------------
    `PHAC_ASSERT_IMPL(a_no_accept_in_clear, clr_active_reg, !s_tready,
        "input accepted during RAM clear")
    `PHAC_ASSERT_IMPL(a_no_item_in_clear, clr_active_reg, !s1_valid_reg,
        "item in flight during RAM clear")
    `PHAC_ASSERT_IMPL(a_peak_bound, 1'b1, peak_reg <= COUNT_LIMIT && peak_reg >= PEAK_RESET,
        "peak out of range")
    `PHAC_ASSERT_IMPL(a_peak_monotonic, $past(aresetn), peak_reg >= $past(peak_reg),
        "peak decreased")
    `PHAC_ASSERT_NEXT(a_write_reaches_out, s1_write, m_tvalid && m_tdata[24:0] != '0,
        "counted item produced no nonzero result")

endmodule

>>> verif/position_histogram_accumulator_tb.sv
`timescale 1ns / 100ps

// Bin counts and the peak are tracked in a local histogram. Expected results
// are checked in transfer order against the m_ stream.
module position_histogram_accumulator_tb;
    import phac_pkg::*;

    localparam int BLOCK_COUNT = 8;
    localparam int BIN_SIDE    = 64;
    localparam int BIN_TOTAL   = BLOCK_COUNT * BIN_SIDE * BIN_SIDE;
    localparam int HOLD_CYCLES = 300;     // long receiver hold-off
    localparam int DRAIN_CYCLES = 8;      // pipeline drain plus margin

    // one event record as it travels on s_
    typedef struct packed {
        logic             mode;
        logic             valid;
        logic [BLK_W-1:0] blk;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             last;
    } hit_rec_t;

    // one result as it travels on m_
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [COUNT_W-1:0] peak;
        logic               skipped;
        logic               done;
    } bin_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;    // block_index[2:0], pos_x[8:3], pos_y[14:9], zero fill
    logic [1:0]  s_tuser = '0;    // mode[0], event_valid[1]
    logic        s_tlast = 1'b0;  // last_in_batch
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;         // bin_count[24:0], peak_count[49:25], zero fill
    logic [0:0]  m_tuser;         // was_skipped[0]
    logic        m_tlast;         // batch_done

    position_histogram_accumulator #(
        .BLOCK_COUNT(BLOCK_COUNT),
        .BIN_SIDE   (BIN_SIDE)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #6 aclk = ~aclk;

    // local histogram state
    logic [COUNT_W-1:0] bin_counts [BIN_TOTAL];
    logic [COUNT_W-1:0] peak_seen;

    hit_rec_t    record_feed_q[$];      // records not yet offered
    bin_result_t predicted_bins_q[$];   // results owed by the block
    hit_rec_t    cur_rec;               // record on s_ right now

    // hot bin: hammered often enough to push the peak past its reset value
    logic [BLK_W-1:0] hot_blk;
    logic [POS_W-1:0] hot_x, hot_y;

    logic idle_enable = 1'b1;
    int   hold_req_cnt = 0;
    int   hold_served = 0;
    int   hold_left, src_gap, sink_gap;
    int   mismatch_count = 0;
    int   n_sent = 0, n_checked = 0, n_incr = 0, n_skip = 0, n_read = 0;

    // apply one accepted record to the local histogram, return its result
    function automatic bin_result_t histogram_update(hit_rec_t rec);
        bin_result_t r;
        int          addr;
        logic        in_range;
        in_range = (rec.blk < BLOCK_COUNT) && (rec.x < BIN_SIDE) && (rec.y < BIN_SIDE);
        addr = (int'(rec.blk) * BIN_SIDE + int'(rec.y)) * BIN_SIDE + int'(rec.x);
        r.count   = '0;
        r.skipped = 1'b0;
        r.done    = rec.last;
        if (in_range) begin
            r.count = bin_counts[addr];
            if (rec.mode == MODE_COUNT) begin
                if (rec.valid) begin
                    if (r.count < COUNT_LIMIT)
                        r.count = r.count + COUNT_W'(1);   // saturates at the limit
                    bin_counts[addr] = r.count;
                    if (r.count > peak_seen)
                        peak_seen = r.count;
                    n_incr++;
                end else begin
                    r.skipped = 1'b1;
                end
            end
        end else if (rec.mode == MODE_COUNT) begin
            r.skipped = 1'b1;
        end
        if (rec.mode == MODE_READ)
            n_read++;
        if (r.skipped)
            n_skip++;
        r.peak = peak_seen;
        return r;
    endfunction

    function automatic hit_rec_t mk_rec(logic mode, logic valid, int blk, int x, int y,
                                        logic last);
        hit_rec_t r;
        r.mode  = mode;
        r.valid = valid;
        r.blk   = blk[BLK_W-1:0];
        r.x     = x[POS_W-1:0];
        r.y     = y[POS_W-1:0];
        r.last  = last;
        return r;
    endfunction

    // mostly counts, weighted toward the hot bin and a small cluster so that
    // bins get revisited back to back
    function automatic hit_rec_t random_rec();
        hit_rec_t r;
        int       pick;
        pick    = $urandom_range(0, 99);
        r.mode  = MODE_COUNT;
        r.valid = 1'b1;
        r.blk   = BLK_W'($urandom);
        r.x     = POS_W'($urandom);
        r.y     = POS_W'($urandom);
        r.last  = ($urandom_range(0, 7) == 0);
        if (pick < 42) begin
            r.blk = hot_blk;
            r.x   = hot_x;
            r.y   = hot_y;
        end else if (pick < 60) begin
            r.x = POS_W'($urandom_range(0, 3));
            r.y = POS_W'($urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0)
                r.mode = MODE_READ;
        end else if (pick < 75) begin
            // plain random count
        end else if (pick < 85) begin
            r.valid = 1'b0;
            if ($urandom_range(0, 1) == 0) begin
                r.blk = hot_blk;
                r.x   = hot_x;
                r.y   = hot_y;
            end
        end else begin
            r.mode  = MODE_READ;
            r.valid = 1'($urandom);
            if ($urandom_range(0, 2) == 0) begin
                r.blk = hot_blk;
                r.x   = hot_x;
                r.y   = hot_y;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] transfer %0d: %s got %0d, expected %0d", $time, n_checked, what,
                 got, want);
        mismatch_count++;
    endtask

    task automatic wait_drained();
        while (record_feed_q.size() != 0 || s_tvalid || predicted_bins_q.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        for (int i = 0; i < BIN_TOTAL; i++)
            bin_counts[i] = '0;
        peak_seen = PEAK_RESET;
    end

    // driver: next record goes out when the slot is free; idle bursts in between
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap  <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted_bins_q.push_back(histogram_update(cur_rec));
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (src_gap > 0) begin
                    src_gap  <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (idle_enable && record_feed_q.size() != 0 &&
                             $urandom_range(0, 9) == 0) begin
                    src_gap  <= $urandom_range(0, 4);   // start an idle burst
                    s_tvalid <= 1'b0;
                end else if (record_feed_q.size() != 0) begin
                    cur_rec  = record_feed_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {1'b0, cur_rec.y, cur_rec.x, cur_rec.blk};
                    s_tuser  <= {cur_rec.valid, cur_rec.mode};
                    s_tlast  <= cur_rec.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver ready: a requested long hold-off first, then random stall bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            sink_gap  <= 0;
        end else if (hold_req_cnt != hold_served) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            m_tready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (sink_gap > 0) begin
            sink_gap <= sink_gap - 1;
            m_tready <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 9) == 0) begin
            sink_gap <= $urandom_range(0, 4);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor: every result transfer against the oldest prediction
    always @(posedge aclk) begin
        bin_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (predicted_bins_q.size() == 0) begin
                report_mismatch("unexpected result, bin_count", 32'(m_tdata[24:0]), 32'd0);
            end else begin
                want = predicted_bins_q.pop_front();
                if (m_tdata[24:0] !== want.count)
                    report_mismatch("bin_count", 32'(m_tdata[24:0]), 32'(want.count));
                if (m_tdata[49:25] !== want.peak)
                    report_mismatch("peak_count", 32'(m_tdata[49:25]), 32'(want.peak));
                if (m_tuser[0] !== want.skipped)
                    report_mismatch("was_skipped", 32'(m_tuser[0]), 32'(want.skipped));
                if (m_tlast !== want.done)
                    report_mismatch("batch_done", 32'(m_tlast), 32'(want.done));
            end
            n_checked++;
        end
    end

    // stimulus
    initial begin
        hot_blk = BLK_W'($urandom);
        hot_x   = POS_W'($urandom);
        hot_y   = POS_W'($urandom);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: untouched bin, corner bins, skipped and read records,
        // back-to-back hits on one bin and on two neighbors
        record_feed_q.push_back(mk_rec(MODE_READ,  1'b0, 0,  0,  0,  1'b0));
        record_feed_q.push_back(mk_rec(MODE_COUNT, 1'b1, 0,  0,  0,  1'b0));
        record_feed_q.push_back(mk_rec(MODE_COUNT, 1'b1, 7, 63, 63,  1'b1));
        record_feed_q.push_back(mk_rec(MODE_COUNT, 1'b0, 7, 63, 63,  1'b0));
        record_feed_q.push_back(mk_rec(MODE_READ,  1'b1, 7, 63, 63,  1'b0));
        record_feed_q.push_back(mk_rec(MODE_READ,  1'b0, 0,  0,  0,  1'b1));
        for (int i = 0; i < 4; i++)
            record_feed_q.push_back(mk_rec(MODE_COUNT, 1'b1, 3, 21, 42, 1'b0));
        for (int i = 0; i < 4; i++)
            record_feed_q.push_back(mk_rec(MODE_COUNT, 1'b1, 3, 21 + (i % 2), 42, 1'b0));
        record_feed_q.push_back(mk_rec(MODE_READ,  1'b0, 3, 21, 42,  1'b0));
        record_feed_q.push_back(mk_rec(MODE_READ,  1'b1, 3, 22, 42,  1'b0));
        record_feed_q.push_back(mk_rec(MODE_COUNT, 1'b1, 5, 63,  0,  1'b0));
        record_feed_q.push_back(mk_rec(MODE_COUNT, 1'b1, 2,  0, 63,  1'b0));
        record_feed_q.push_back(mk_rec(MODE_COUNT, 1'b0, 4, 42, 21,  1'b1));
        record_feed_q.push_back(mk_rec(MODE_READ,  1'b1, 4, 42, 21,  1'b1));
        wait_drained();

        // long receiver hold-off with the sender still pushing
        for (int i = 0; i < 40; i++)
            record_feed_q.push_back(random_rec());
        @(posedge aclk);
        hold_req_cnt <= hold_req_cnt + 1;
        wait_drained();

        // random traffic with idling on both sides
        for (int i = 0; i < 680; i++)
            record_feed_q.push_back(random_rec());
        wait_drained();

        // closing stretch at full rate
        @(posedge aclk);
        idle_enable <= 1'b0;
        for (int i = 0; i < 110; i++)
            record_feed_q.push_back(random_rec());
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d transfers: %0d bin increments, %0d skipped, %0d reads",
                 n_sent, n_incr, n_skip, n_read);
        $display("final peak %0d, hot bin count %0d", peak_seen,
                 bin_counts[(int'(hot_blk) * BIN_SIDE + int'(hot_y)) * BIN_SIDE + int'(hot_x)]);
        if (mismatch_count == 0) begin
            $display("position_histogram_accumulator: match");
        end else begin
            $display("position_histogram_accumulator: mismatch");
        end
        $finish;
    end

    // watchdog: covers the post-reset clear sweep several times over
    initial begin
        #4_000_000;
        $display("timeout with %0d results outstanding", predicted_bins_q.size());
        $display("position_histogram_accumulator: mismatch");
        $finish;
    end

endmodule
